>>> rtl/core/dep_pkg.sv
// Shared command codes, status codes and control types of the double-ended priority queue.
package dep_pkg;

  localparam int unsigned FuncWidth   = 3;
  localparam int unsigned StatusWidth = 2;

  localparam logic [FuncWidth-1:0] FN_INSERT  = 3'd0;
  localparam logic [FuncWidth-1:0] FN_EXT_MIN = 3'd1;
  localparam logic [FuncWidth-1:0] FN_PEEK_MIN = 3'd2;
  localparam logic [FuncWidth-1:0] FN_EXT_MAX = 3'd3;
  localparam logic [FuncWidth-1:0] FN_PEEK_MAX = 3'd4;
  localparam logic [FuncWidth-1:0] FN_COUNT   = 3'd5;
  localparam logic [FuncWidth-1:0] FN_CLEAR   = 3'd6;

  localparam logic [StatusWidth-1:0] STS_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] STS_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic pop;
    logic push;
    logic clear;
  } pool_cmd_t;

endpackage

>>> rtl/core/double_ended_priority_queue.sv
// Double-ended priority queue: twin min/max heaps in one memory, walked by a sequencer.
// One command at a time; the heap memory read port (one slot per cycle) and the
// single comparator bound the speed of insert and extract. Reset empties the queue
// at once, no clearing pass.
module double_ended_priority_queue
  import dep_pkg::*;
#(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [FuncWidth-1:0]          func_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [StatusWidth-1:0]        status_o,
  output logic signed [VALUE_WIDTH-1:0] result_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);

  localparam int unsigned TW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = TW + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TAG  = 4'd1;
  localparam logic [3:0] ST_TOP  = 4'd2;
  localparam logic [3:0] ST_TOPD = 4'd3;
  localparam logic [3:0] ST_OTH  = 4'd4;
  localparam logic [3:0] ST_RM   = 4'd5;
  localparam logic [3:0] ST_RMX  = 4'd6;
  localparam logic [3:0] ST_UP   = 4'd7;
  localparam logic [3:0] ST_UPD  = 4'd8;
  localparam logic [3:0] ST_DN   = 4'd9;
  localparam logic [3:0] ST_DNL  = 4'd10;
  localparam logic [3:0] ST_DNR  = 4'd11;
  localparam logic [3:0] ST_DNC  = 4'd12;
  localparam logic [3:0] ST_NEXT = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  logic [3:0]                    state_q, state_d;
  logic [FuncWidth-1:0]          func_q, func_d;
  logic                          hsel_q, hsel_d;
  logic                          phase_q, phase_d;
  logic                          try_dn_q, try_dn_d;
  logic [TW-1:0]                 idx_q, idx_d;
  logic [TW-1:0]                 other_q, other_d;
  logic [TW-1:0]                 top_tag_q, top_tag_d;
  logic signed [VALUE_WIDTH-1:0] x_val_q, x_val_d;
  logic [TW-1:0]                 x_tag_q, x_tag_d;
  logic signed [VALUE_WIDTH-1:0] c_val_q, c_val_d;
  logic [TW-1:0]                 c_tag_q, c_tag_d;
  logic [TW-1:0]                 c_idx_q, c_idx_d;
  logic [StatusWidth-1:0]        sts_q, sts_d;
  logic signed [VALUE_WIDTH-1:0] res_q, res_d;
  logic [CW-1:0]                 count_q, count_d;
  logic                          out_valid_q;
  logic [StatusWidth-1:0]        out_sts_q;
  logic signed [VALUE_WIDTH-1:0] out_res_q;
  logic [CW-1:0]                 out_cnt_q;

  logic [TW:0]                   slot_raddr, pos_raddr, slot_waddr, pos_waddr;
  logic                          slot_we, pos_we;
  logic signed [VALUE_WIDTH-1:0] slot_wval, slot_rval;
  logic [TW-1:0]                 slot_wtag, slot_rtag, pos_wdata, pos_rdata;
  pool_cmd_t                     pool_cmd;
  logic [TW-1:0]                 pool_tag;

  logic signed [VALUE_WIDTH-1:0] cmp_a, cmp_b;
  logic                          above;
  logic [CW-1:0]                 last;
  logic [TW-1:0]                 parent;
  logic [LW-1:0]                 left, right, lim;
  logic                          is_peek, is_extract, out_free, accept;

  assign last     = count_q - 1'b1;
  assign parent   = (idx_q - 1'b1) >> 1;
  assign left     = {1'b0, idx_q, 1'b0} + LW'(1);
  assign right    = left + LW'(1);
  assign lim      = LW'(last);
  assign is_peek  = (func_q == FN_PEEK_MIN) || (func_q == FN_PEEK_MAX);
  assign is_extract = (func_q == FN_EXT_MIN) || (func_q == FN_EXT_MAX);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == ST_IDLE);

  // The one comparator: "a stands above b" in the heap being walked
  always_comb begin
    unique case (state_q)
      ST_UPD: begin
        cmp_a = x_val_q;
        cmp_b = slot_rval;
      end
      ST_DNR: begin
        cmp_a = slot_rval;
        cmp_b = c_val_q;
      end
      default: begin
        cmp_a = c_val_q;
        cmp_b = x_val_q;
      end
    endcase
    above = hsel_q ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
  end

  always_comb begin
    unique case (state_q)
      ST_TOP:        slot_raddr = {hsel_q, {TW{1'b0}}};
      ST_RM:         slot_raddr = {hsel_q, last[TW-1:0]};
      ST_DN:         slot_raddr = {hsel_q, left[TW-1:0]};
      ST_DNL:        slot_raddr = {hsel_q, right[TW-1:0]};
      default:       slot_raddr = {hsel_q, parent};
    endcase
  end
  assign pos_raddr = {~hsel_q, slot_rtag};

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    hsel_d    = hsel_q;
    phase_d   = phase_q;
    try_dn_d  = try_dn_q;
    idx_d     = idx_q;
    other_d   = other_q;
    top_tag_d = top_tag_q;
    x_val_d   = x_val_q;
    x_tag_d   = x_tag_q;
    c_val_d   = c_val_q;
    c_tag_d   = c_tag_q;
    c_idx_d   = c_idx_q;
    sts_d     = sts_q;
    res_d     = res_q;
    count_d   = count_q;
    pool_cmd  = '0;
    slot_we   = 1'b0;
    pos_we    = 1'b0;
    slot_wval = x_val_q;
    slot_wtag = x_tag_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d  = func_i;
          x_val_d = value_i;
          hsel_d  = (func_i == FN_EXT_MAX) || (func_i == FN_PEEK_MAX);
          phase_d = 1'b0;
          sts_d   = STS_OK;
          res_d   = '0;
          state_d = ST_DONE;
          unique case (func_i)
            FN_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                sts_d = STS_FULL;
              end else begin
                pool_cmd.pop = 1'b1;
                state_d      = ST_TAG;
              end
            end
            FN_EXT_MIN, FN_PEEK_MIN, FN_EXT_MAX, FN_PEEK_MAX: begin
              if (count_q == '0) begin
                sts_d = STS_EMPTY;
              end else begin
                state_d = ST_TOP;
              end
            end
            FN_CLEAR: begin
              pool_cmd.clear = 1'b1;
              count_d        = '0;
            end
            default: ;
          endcase
        end
      end
      ST_TAG: begin
        x_tag_d  = pool_tag;
        idx_d    = count_q[TW-1:0];
        hsel_d   = 1'b0;
        try_dn_d = 1'b0;
        state_d  = ST_UP;
      end
      ST_TOP: state_d = ST_TOPD;
      ST_TOPD: begin
        res_d     = slot_rval;
        top_tag_d = slot_rtag;
        state_d   = is_peek ? ST_DONE : ST_OTH;
      end
      ST_OTH: begin
        other_d = pos_rdata;
        idx_d   = '0;
        state_d = ST_RM;
      end
      ST_RM: begin
        // removing the last slot leaves nothing to repair
        state_d = (CW'(idx_q) == last) ? ST_NEXT : ST_RMX;
      end
      ST_RMX: begin
        x_val_d  = slot_rval;
        x_tag_d  = slot_rtag;
        try_dn_d = 1'b1;
        state_d  = (idx_q != '0) ? ST_UPD : ST_DN;
      end
      ST_UP: begin
        if (idx_q == '0) begin
          slot_we = 1'b1;
          pos_we  = 1'b1;
          state_d = ST_NEXT;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (above) begin
          slot_wval = slot_rval;
          slot_wtag = slot_rtag;
          slot_we   = 1'b1;
          pos_we    = 1'b1;
          idx_d     = parent;
          try_dn_d  = 1'b0;
          state_d   = ST_UP;
        end else if (try_dn_q) begin
          state_d = ST_DN;
        end else begin
          slot_we = 1'b1;
          pos_we  = 1'b1;
          state_d = ST_NEXT;
        end
      end
      ST_DN: begin
        if (left >= lim) begin
          slot_we = 1'b1;
          pos_we  = 1'b1;
          state_d = ST_NEXT;
        end else begin
          state_d = ST_DNL;
        end
      end
      ST_DNL: begin
        c_val_d = slot_rval;
        c_tag_d = slot_rtag;
        c_idx_d = left[TW-1:0];
        state_d = (right < lim) ? ST_DNR : ST_DNC;
      end
      ST_DNR: begin
        if (above) begin
          c_val_d = slot_rval;
          c_tag_d = slot_rtag;
          c_idx_d = right[TW-1:0];
        end
        state_d = ST_DNC;
      end
      ST_DNC: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (above) begin
          slot_wval = c_val_q;
          slot_wtag = c_tag_q;
          idx_d     = c_idx_q;
          state_d   = ST_DN;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          if (is_extract) begin
            // repair the twin heap at the slot that held the extracted tag
            hsel_d  = ~hsel_q;
            idx_d   = other_q;
            state_d = ST_RM;
          end else begin
            hsel_d   = 1'b1;
            idx_d    = count_q[TW-1:0];
            try_dn_d = 1'b0;
            state_d  = ST_UP;
          end
        end else begin
          if (is_extract) begin
            pool_cmd.push = 1'b1;
            count_d       = last;
          end else begin
            count_d = count_q + 1'b1;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign slot_waddr = {hsel_q, idx_q};
  assign pos_waddr  = {hsel_q, slot_wtag};
  assign pos_wdata  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    hsel_q    <= hsel_d;
    phase_q   <= phase_d;
    try_dn_q  <= try_dn_d;
    idx_q     <= idx_d;
    other_q   <= other_d;
    top_tag_q <= top_tag_d;
    x_val_q   <= x_val_d;
    x_tag_q   <= x_tag_d;
    c_val_q   <= c_val_d;
    c_tag_q   <= c_tag_d;
    c_idx_q   <= c_idx_d;
    sts_q     <= sts_d;
    res_q     <= res_d;
    if (state_q == ST_DONE && out_free) begin
      out_sts_q <= sts_q;
      out_res_q <= res_q;
      out_cnt_q <= count_q;
    end
  end

  dep_heap_ram #(
    .TagWidth  (TW),
    .ValueWidth(VALUE_WIDTH)
  ) u_heap_ram (
    .clk_i       (clk_i),
    .slot_raddr_i(slot_raddr),
    .slot_we_i   (slot_we),
    .slot_waddr_i(slot_waddr),
    .slot_wval_i (slot_wval),
    .slot_wtag_i (slot_wtag),
    .slot_rval_o (slot_rval),
    .slot_rtag_o (slot_rtag),
    .pos_raddr_i (pos_raddr),
    .pos_we_i    (pos_we),
    .pos_waddr_i (pos_waddr),
    .pos_wdata_i (pos_wdata),
    .pos_rdata_o (pos_rdata)
  );

  dep_tag_pool #(
    .TagWidth(TW)
  ) u_tag_pool (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (pool_cmd),
    .push_tag_i(top_tag_q),
    .tag_o     (pool_tag)
  );

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_sts_q;
  assign result_value_o = out_res_q;
  assign entry_count_o  = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STS_FULL) |-> (entry_count_o == CW'(CAPACITY)))
    else $error("full status with free room");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STS_EMPTY) |-> (entry_count_o == '0))
    else $error("empty status with stored values");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STS_OK) |-> (result_value_o == '0))
    else $error("error transaction carries a value");

endmodule

>>> rtl/core/dep_heap_ram.sv
// Slot memory (value and tag) and tag-to-slot position memory for both heaps.
module dep_heap_ram
  import dep_pkg::*;
#(
  parameter int unsigned TagWidth   = 8,
  parameter int unsigned ValueWidth = 32
) (
  input  logic                         clk_i,
  input  logic [TagWidth:0]            slot_raddr_i,
  input  logic                         slot_we_i,
  input  logic [TagWidth:0]            slot_waddr_i,
  input  logic signed [ValueWidth-1:0] slot_wval_i,
  input  logic [TagWidth-1:0]          slot_wtag_i,
  output logic signed [ValueWidth-1:0] slot_rval_o,
  output logic [TagWidth-1:0]          slot_rtag_o,
  input  logic [TagWidth:0]            pos_raddr_i,
  input  logic                         pos_we_i,
  input  logic [TagWidth:0]            pos_waddr_i,
  input  logic [TagWidth-1:0]          pos_wdata_i,
  output logic [TagWidth-1:0]          pos_rdata_o
);

  localparam int unsigned Depth = 2 * (1 << TagWidth);

  logic [TagWidth+ValueWidth-1:0] slot_mem [Depth];
  logic [TagWidth-1:0]            pos_mem  [Depth];
  logic [TagWidth+ValueWidth-1:0] slot_rd_q;
  logic [TagWidth-1:0]            pos_rd_q;

  always_ff @(posedge clk_i) begin
    if (slot_we_i) begin
      slot_mem[slot_waddr_i] <= {slot_wtag_i, slot_wval_i};
    end
    slot_rd_q <= slot_mem[slot_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we_i) begin
      pos_mem[pos_waddr_i] <= pos_wdata_i;
    end
    pos_rd_q <= pos_mem[pos_raddr_i];
  end

  assign slot_rval_o = $signed(slot_rd_q[ValueWidth-1:0]);
  assign slot_rtag_o = slot_rd_q[TagWidth+ValueWidth-1:ValueWidth];
  assign pos_rdata_o = pos_rd_q;

endmodule

>>> rtl/core/dep_tag_pool.sv
// Free tag pool: a stack of returned tags backed by a counter of never-used tags.
module dep_tag_pool
  import dep_pkg::*;
#(
  parameter int unsigned TagWidth = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pool_cmd_t           cmd_i,
  input  logic [TagWidth-1:0] push_tag_i,
  output logic [TagWidth-1:0] tag_o
);

  localparam int unsigned Depth = 1 << TagWidth;

  logic [TagWidth-1:0] stack_mem [Depth];
  logic [TagWidth:0]   sp_q, sp_d;
  logic [TagWidth:0]   fresh_q, fresh_d;
  logic                use_fresh_q, use_fresh_d;
  logic [TagWidth-1:0] fresh_tag_q;
  logic [TagWidth-1:0] stack_rd_q;
  logic [TagWidth:0]   sp_dec;

  assign sp_dec = sp_q - 1'b1;

  always_comb begin
    sp_d        = sp_q;
    fresh_d     = fresh_q;
    use_fresh_d = use_fresh_q;
    priority if (cmd_i.clear) begin
      sp_d    = '0;
      fresh_d = '0;
    end else if (cmd_i.pop) begin
      if (sp_q != '0) begin
        sp_d        = sp_dec;
        use_fresh_d = 1'b0;
      end else begin
        fresh_d     = fresh_q + 1'b1;
        use_fresh_d = 1'b1;
      end
    end else if (cmd_i.push) begin
      sp_d = sp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      fresh_q     <= '0;
      use_fresh_q <= 1'b0;
    end else begin
      sp_q        <= sp_d;
      fresh_q     <= fresh_d;
      use_fresh_q <= use_fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.clear) begin
      stack_mem[sp_q[TagWidth-1:0]] <= push_tag_i;
    end
    stack_rd_q  <= stack_mem[sp_dec[TagWidth-1:0]];
    fresh_tag_q <= fresh_q[TagWidth-1:0];
  end

  assign tag_o = use_fresh_q ? fresh_tag_q : stack_rd_q;

endmodule

>>> dv/tb_double_ended_priority_queue.sv
// Testbench for the double-ended priority queue: directed and random commands checked against a value model.
module tb_double_ended_priority_queue;
  import dep_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity = 256;
  localparam int unsigned CntWidth = $clog2(Capacity + 1);
  // command code with no function assigned
  localparam logic [FuncWidth-1:0] FnUnused = 3'd7;

  typedef struct {
    logic [StatusWidth-1:0] status;
    logic signed [31:0]     value;
    logic [CntWidth-1:0]    count;
  } dep_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [FuncWidth-1:0]   func_i;
  logic signed [31:0]     value_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [StatusWidth-1:0] status_o;
  logic signed [31:0]     result_value_o;
  logic [CntWidth-1:0]    entry_count_o;

  double_ended_priority_queue #(
    .CAPACITY(Capacity),
    .VALUE_WIDTH(32)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .func_i(func_i),
    .value_i(value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o(status_o),
    .result_value_o(result_value_o),
    .entry_count_o(entry_count_o)
  );

  // queue contents as a plain multiset; heap order is invisible from outside
  int          stored_values[$];
  dep_result_t pending_results[$];
  int          fail_count = 0;
  bit          quiet = 1'b0;
  int          out_burst = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int find_extreme(bit want_max);
    int idx;
    idx = 0;
    for (int k = 1; k < stored_values.size(); k++) begin
      if (want_max ? stored_values[k] > stored_values[idx]
                   : stored_values[k] < stored_values[idx]) idx = k;
    end
    return idx;
  endfunction

  function automatic dep_result_t predict_command(logic [FuncWidth-1:0] fn, int val);
    dep_result_t r;
    int idx;
    r.status = STS_OK;
    r.value  = 0;
    case (fn)
      FN_INSERT: begin
        if (stored_values.size() >= Capacity) r.status = STS_FULL;
        else stored_values.insert(stored_values.size(), val);
      end
      FN_EXT_MIN, FN_PEEK_MIN, FN_EXT_MAX, FN_PEEK_MAX: begin
        if (stored_values.size() == 0) begin
          r.status = STS_EMPTY;
        end else begin
          idx = find_extreme(fn == FN_EXT_MAX || fn == FN_PEEK_MAX);
          r.value = stored_values[idx];
          if (fn == FN_EXT_MIN || fn == FN_EXT_MAX) stored_values.delete(idx);
        end
      end
      FN_CLEAR: stored_values.delete();
      default: ;
    endcase
    r.count = CntWidth'(stored_values.size());
    return r;
  endfunction

  // Hold the transaction until accepted, then optionally drop valid for a burst.
  task automatic send_command(logic [FuncWidth-1:0] fn, int val);
    int gap;
    dep_result_t exp_r;
    in_valid_i <= 1'b1;
    func_i     <= fn;
    value_i    <= val;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    exp_r = predict_command(fn, val);
    pending_results.insert(pending_results.size(), exp_r);
    gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      out_burst   <= 0;
    end else if (out_burst > 0) begin
      out_burst <= out_burst - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      out_burst   <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    dep_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result without pending command: status=%0d value=%0d count=%0d",
               status_o, result_value_o, entry_count_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status_o);
          fail_count++;
        end
        if (result_value_o !== exp_r.value) begin
          $error("result_value expected %0d actual %0d", exp_r.value, result_value_o);
          fail_count++;
        end
        if (entry_count_o !== exp_r.count) begin
          $error("entry_count expected %0d actual %0d", exp_r.count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_command(FN_EXT_MIN, 0);
    send_command(FN_PEEK_MIN, 0);
    send_command(FN_EXT_MAX, 0);
    send_command(FN_PEEK_MAX, 0);
    send_command(FN_COUNT, 0);
    send_command(FnUnused, 32'h5a5a_a5a5);
  endtask

  task automatic test_extreme_values();
    send_command(FN_INSERT, 32'h8000_0000);
    send_command(FN_INSERT, 32'h7fff_ffff);
    send_command(FN_INSERT, 0);
    send_command(FN_INSERT, -1);
    send_command(FN_INSERT, 7);
    send_command(FN_INSERT, 7);
    send_command(FN_PEEK_MIN, 0);
    send_command(FN_PEEK_MAX, 0);
    send_command(FN_EXT_MAX, 0);
    send_command(FN_EXT_MIN, 0);
    send_command(FN_EXT_MAX, 0);
    send_command(FN_EXT_MAX, 0);
    send_command(FnUnused, 0);
    send_command(FN_COUNT, 0);
    send_command(FN_CLEAR, 0);
    send_command(FN_PEEK_MAX, 0);
  endtask

  task automatic test_full_queue();
    for (int k = 0; k < Capacity; k++) send_command(FN_INSERT, $urandom_range(0, 1000) - 500);
    send_command(FN_INSERT, 1);
    send_command(FN_EXT_MIN, 0);
    send_command(FN_INSERT, 32'h7fff_ffff);
    send_command(FN_INSERT, 2);
    send_command(FN_EXT_MAX, 0);
    send_command(FN_CLEAR, 0);
    send_command(FN_COUNT, 0);
  endtask

  task automatic test_random_mix(int items);
    int pick;
    int val;
    for (int n = 0; n < items; n++) begin
      if (n == items - 150) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      val  = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 40) - 20;
      if (pick < 45)      send_command(FN_INSERT, val);
      else if (pick < 60) send_command(FN_EXT_MIN, val);
      else if (pick < 75) send_command(FN_EXT_MAX, val);
      else if (pick < 83) send_command(FN_PEEK_MIN, val);
      else if (pick < 91) send_command(FN_PEEK_MAX, val);
      else if (pick < 95) send_command(FN_COUNT, val);
      else if (pick < 97) send_command(FN_CLEAR, val);
      else                send_command(FnUnused, val);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FN_COUNT;
    value_i     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_extreme_values();
    test_full_queue();
    test_random_mix(515);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("tb_double_ended_priority_queue OK");
    else $display("tb_double_ended_priority_queue NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_double_ended_priority_queue NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/dep_pkg.sv
rtl/core/dep_heap_ram.sv
rtl/core/dep_tag_pool.sv
rtl/core/double_ended_priority_queue.sv
dv/tb_double_ended_priority_queue.sv
